// ===== sv/hlpc_pkg.sv =====
// ----------------------------------------------------------------------------
// HSV LUT pixel correction package
// Shared widths, default table geometry and command codes.
// ----------------------------------------------------------------------------
package hlpc_pkg;

  localparam int HUE_BINS_DEF = 32;
  localparam int SAT_BINS_DEF = 16;

  localparam int PIX_W   = 8;    // hue, sat, val
  localparam int INDEX_W = 9;
  localparam int DH_W    = 13;
  localparam int DS_W    = 14;
  localparam int DV_W    = 14;
  localparam int ENTRY_W = DH_W + DS_W + DV_W;

  localparam int FRAC_W  = 10;   // blend weight fraction bits
  localparam int WEIGHT_ONE = 1 << FRAC_W;

  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_WRITE = 1'b1;

endpackage

// ===== sv/hsv_lut_pixel_correction.sv =====
// ----------------------------------------------------------------------------
// HSV LUT pixel correction
// Bilinear hue-by-saturation delta table applied to 8-bit HSV pixels.
// ----------------------------------------------------------------------------
//  channel | handshake          | payload
//  --------+--------------------+-----------------------------------------------
//  in      | in_valid/in_ready  | command hue sat val table_index delta_hue
//          |                    | delta_sat delta_val
//  out     | out_valid/out_ready| hue_out sat_out val_out (pixel beats only)
//
//  One beat per clock sustained while the output is taken. A pixel beat passes
//  through registers A, B, C, D and E into the output register; a write beat
//  updates the table from the stage A register and yields no output beat.
//  After reset a clearing pass writes zeros to every table entry, one per
//  cycle, HUE_BINS*SAT_BINS entries (512 at the defaults); in_ready stays low.
//  All stages advance together: when the output register holds an untaken
//  beat, the whole pipe holds and in_ready drops.
// ----------------------------------------------------------------------------
module hsv_lut_pixel_correction
  import hlpc_pkg::*;
#(
  parameter int HUE_BINS = HUE_BINS_DEF,
  parameter int SAT_BINS = SAT_BINS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      command,
  input  logic [PIX_W-1:0]          hue,
  input  logic [PIX_W-1:0]          sat,
  input  logic [PIX_W-1:0]          val,
  input  logic [INDEX_W-1:0]        table_index,
  input  logic signed [DH_W-1:0]    delta_hue,
  input  logic signed [DS_W-1:0]    delta_sat,
  input  logic signed [DV_W-1:0]    delta_val,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [PIX_W-1:0]          hue_out,
  output logic [PIX_W-1:0]          sat_out,
  output logic [PIX_W-1:0]          val_out
);

  localparam int TABLE_SIZE = HUE_BINS * SAT_BINS;
  localparam int AW = $clog2(TABLE_SIZE);
  localparam int HW = $clog2(HUE_BINS);
  localparam int SW = $clog2(SAT_BINS);
  localparam int WW = 2 * FRAC_W + 1;       // corner weight, up to 2^20
  localparam int PW = WW + 1 + DS_W;        // signed weight x delta
  localparam int BW = PW + 2;               // sum of four corners
  localparam int HHW = 36;                  // hue accumulator, 2^-25 units
  localparam int XW = 48;                   // sat/val accumulator, 2^-32 units

  localparam logic signed [HHW-1:0] HUE_FULL = HHW'(64'sd180 <<< 25);
  localparam logic signed [HHW-1:0] HUE_HALF = HHW'(64'sd1 <<< 24);
  localparam logic signed [XW-1:0]  X_TOP    = XW'(64'sd255 <<< 32);
  localparam logic signed [XW-1:0]  X_HALF   = XW'(64'sd1 <<< 31);

  // Position tables, indexed by the raw 8-bit input.
  // Hue entry: {h0, h1, hf}; sat entry: {s0, s1, sf}.
  typedef logic [2*HW+FRAC_W-1:0] hue_lut_t [256];
  typedef logic [2*SW+FRAC_W-1:0] sat_lut_t [256];

  function automatic hue_lut_t build_hue_lut();
    hue_lut_t t;
    int hr, ph, b;
    for (int i = 0; i < 256; i++) begin
      hr = (i >= 180) ? i - 180 : i;
      ph = (hr * HUE_BINS * WEIGHT_ONE) / 180;
      b  = (ph >> FRAC_W) % HUE_BINS;
      t[i] = {HW'(b), HW'((b + 1) % HUE_BINS), FRAC_W'(ph % WEIGHT_ONE)};
    end
    return t;
  endfunction

  function automatic sat_lut_t build_sat_lut();
    sat_lut_t t;
    int ps, s0, s1;
    for (int i = 0; i < 256; i++) begin
      ps = (i * (SAT_BINS - 1) * WEIGHT_ONE) / 255;
      s0 = ps >> FRAC_W;
      if (s0 > SAT_BINS - 1) s0 = SAT_BINS - 1;
      s1 = (s0 + 1 < SAT_BINS) ? s0 + 1 : SAT_BINS - 1;
      t[i] = {SW'(s0), SW'(s1), FRAC_W'(ps - s0 * WEIGHT_ONE)};
    end
    return t;
  endfunction

  localparam hue_lut_t HUE_LUT = build_hue_lut();
  localparam sat_lut_t SAT_LUT = build_sat_lut();

  // Global advance: the pipe moves whenever the output register can take a beat.
  logic adv;
  logic clearing;
  logic [AW-1:0] clr_addr;

  assign adv      = !out_valid || out_ready;
  assign in_ready = adv && !clearing;

  // Clearing pass after reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == AW'(TABLE_SIZE - 1)) clearing <= 1'b0;
    end
  end

  // ---------------- stage A: register the beat and its table positions -------
  logic                   a_valid;
  logic                   a_cmd;
  logic [PIX_W-1:0]       a_hue, a_sat, a_val;
  logic [INDEX_W-1:0]     a_index;
  logic signed [DH_W-1:0] a_dh;
  logic signed [DS_W-1:0] a_ds;
  logic signed [DV_W-1:0] a_dv;
  logic [HW-1:0]          a_h0, a_h1;
  logic [SW-1:0]          a_s0, a_s1;
  logic [FRAC_W-1:0]      a_hf, a_sf;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (adv) begin
      a_valid <= in_valid && in_ready;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_cmd   <= command;
      // Fold out-of-range hue back into 0..179.
      a_hue   <= (hue >= PIX_W'(180)) ? hue - PIX_W'(180) : hue;
      a_sat   <= sat;
      a_val   <= val;
      a_index <= table_index;
      a_dh    <= delta_hue;
      a_ds    <= delta_sat;
      a_dv    <= delta_val;
      {a_h0, a_h1, a_hf} <= HUE_LUT[hue];
      {a_s0, a_s1, a_sf} <= SAT_LUT[sat];
    end
  end

  // ---------------- table: four copies, one read port each -------------------
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [ENTRY_W-1:0] mem_wdata;
  logic [AW-1:0]     rd_addr [4];
  logic [ENTRY_W-1:0] rd_data [4];
  logic              wr_hit;

  assign wr_hit    = (int'(a_index) < TABLE_SIZE);
  assign mem_we    = clearing || (adv && a_valid && a_cmd == CMD_WRITE && wr_hit);
  assign mem_waddr = clearing ? clr_addr : AW'(a_index);
  assign mem_wdata = clearing ? '0 : {a_dh, a_ds, a_dv};

  // Corner order: 00, 01, 10, 11 (hue bin, sat bin).
  assign rd_addr[0] = AW'(a_h0 * SAT_BINS + a_s0);
  assign rd_addr[1] = AW'(a_h0 * SAT_BINS + a_s1);
  assign rd_addr[2] = AW'(a_h1 * SAT_BINS + a_s0);
  assign rd_addr[3] = AW'(a_h1 * SAT_BINS + a_s1);

  for (genvar g = 0; g < 4; g++) begin : g_bank
    logic [ENTRY_W-1:0] mem [TABLE_SIZE];
    always_ff @(posedge clk) begin
      if (mem_we) mem[mem_waddr] <= mem_wdata;
      if (adv) rd_data[g] <= mem[rd_addr[g]];
    end
  end

  // ---------------- stage B: corner weights and table data --------------------
  logic              b_valid;
  logic [PIX_W-1:0]  b_hue, b_sat, b_val;
  logic [WW-1:0]     b_w [4];
  logic [FRAC_W:0]   wh0, wh1, ws0, ws1;

  assign wh0 = (FRAC_W + 1)'(WEIGHT_ONE) - {1'b0, a_hf};
  assign wh1 = {1'b0, a_hf};
  assign ws0 = (FRAC_W + 1)'(WEIGHT_ONE) - {1'b0, a_sf};
  assign ws1 = {1'b0, a_sf};

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (adv) begin
      b_valid <= a_valid && a_cmd == CMD_PIXEL;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b_hue  <= a_hue;
      b_sat  <= a_sat;
      b_val  <= a_val;
      b_w[0] <= WW'(wh0) * WW'(ws0);
      b_w[1] <= WW'(wh0) * WW'(ws1);
      b_w[2] <= WW'(wh1) * WW'(ws0);
      b_w[3] <= WW'(wh1) * WW'(ws1);
    end
  end

  // ---------------- stage C: weight times delta -------------------------------
  logic              c_valid;
  logic [PIX_W-1:0]  c_hue, c_sat, c_val;
  logic signed [PW-1:0] c_ph [4];
  logic signed [PW-1:0] c_ps [4];
  logic signed [PW-1:0] c_pv [4];

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else if (adv) begin
      c_valid <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c_hue <= b_hue;
      c_sat <= b_sat;
      c_val <= b_val;
      for (int k = 0; k < 4; k++) begin
        c_ph[k] <= PW'($signed({1'b0, b_w[k]})) *
                   PW'($signed(rd_data[k][ENTRY_W-1 -: DH_W]));
        c_ps[k] <= PW'($signed({1'b0, b_w[k]})) *
                   PW'($signed(rd_data[k][DS_W+DV_W-1 -: DS_W]));
        c_pv[k] <= PW'($signed({1'b0, b_w[k]})) *
                   PW'($signed(rd_data[k][DV_W-1:0]));
      end
    end
  end

  // ---------------- stage D: blend sums ---------------------------------------
  logic              d_valid;
  logic [PIX_W-1:0]  d_hue, d_sat, d_val;
  logic signed [BW-1:0] d_bh, d_bs, d_bv;

  always_ff @(posedge clk) begin
    if (rst) begin
      d_valid <= 1'b0;
    end else if (adv) begin
      d_valid <= c_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d_hue <= c_hue;
      d_sat <= c_sat;
      d_val <= c_val;
      d_bh  <= BW'(c_ph[0]) + BW'(c_ph[1]) + BW'(c_ph[2]) + BW'(c_ph[3]);
      d_bs  <= BW'(c_ps[0]) + BW'(c_ps[1]) + BW'(c_ps[2]) + BW'(c_ps[3]);
      d_bv  <= BW'(c_pv[0]) + BW'(c_pv[1]) + BW'(c_pv[2]) + BW'(c_pv[3]);
    end
  end

  // ---------------- stage E: add pixel to blended delta ------------------------
  logic              e_valid;
  logic signed [HHW-1:0] e_hh;
  logic signed [XW-1:0]  e_xs, e_xv;

  always_ff @(posedge clk) begin
    if (rst) begin
      e_valid <= 1'b0;
    end else if (adv) begin
      e_valid <= d_valid;
    end
  end

  // Half a 1/16-degree delta is one 2^-25 half-degree unit: add B as is.
  // Sat and val scale B by 255 as (B << 8) - B.
  always_ff @(posedge clk) begin
    if (adv) begin
      e_hh <= $signed({3'b000, d_hue, 25'd0}) + HHW'(d_bh);
      e_xs <= $signed({8'd0, d_sat, 32'd0}) + (XW'(d_bs) <<< 8) - XW'(d_bs);
      e_xv <= $signed({8'd0, d_val, 32'd0}) + (XW'(d_bv) <<< 8) - XW'(d_bv);
    end
  end

  // ---------------- output: wrap, clamp and round -----------------------------
  logic signed [HHW-1:0] hh_wrap, hh_rnd;
  logic [PIX_W-1:0]      hue_rnd;
  logic signed [XW-1:0]  xs_clip, xv_clip, xs_rnd, xv_rnd;

  always_comb begin
    // One correction suffices: the blend never exceeds 2^32 in magnitude.
    if (e_hh < 0) begin
      hh_wrap = e_hh + HUE_FULL;
    end else if (e_hh >= HUE_FULL) begin
      hh_wrap = e_hh - HUE_FULL;
    end else begin
      hh_wrap = e_hh;
    end
    hh_rnd  = hh_wrap + HUE_HALF;
    hue_rnd = hh_rnd[25 +: PIX_W];
    if (hue_rnd >= PIX_W'(180)) hue_rnd = '0;

    if (e_xs < 0) begin
      xs_clip = '0;
    end else if (e_xs > X_TOP) begin
      xs_clip = X_TOP;
    end else begin
      xs_clip = e_xs;
    end
    xs_rnd = xs_clip + X_HALF;

    if (e_xv < 0) begin
      xv_clip = '0;
    end else if (e_xv > X_TOP) begin
      xv_clip = X_TOP;
    end else begin
      xv_clip = e_xv;
    end
    xv_rnd = xv_clip + X_HALF;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= e_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      hue_out <= hue_rnd;
      sat_out <= xs_rnd[32 +: PIX_W];
      val_out <= xv_rnd[32 +: PIX_W];
    end
  end

endmodule
